// ----- sv/kcced_pkg.sv -----
// Shared types and constants for the key color change event detector.
// Holds the result record, register indexes and the white key lookup mask.
// Depends on nothing.
package kcced_pkg;

  localparam int unsigned KEY_W       = 7;
  localparam int unsigned CHAN_W      = 8;
  localparam int unsigned DIFF_W      = 10;
  localparam int unsigned FRAME_W     = 24;
  localparam int unsigned COUNT_W     = 7;
  localparam int unsigned TEXT_W      = 9;
  localparam int unsigned CFG_IDX_W   = 8;
  localparam int unsigned CFG_DATA_W  = 10;
  localparam int unsigned IN_DATA_W   = 32;
  localparam int unsigned OUT_DATA_W  = 56;

  localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_THRESHOLD  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WHITE_REF_BLUE    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WHITE_REF_GREEN   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WHITE_REF_RED     = 8'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BLACK_REF_BLUE    = 8'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BLACK_REF_GREEN   = 8'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BLACK_REF_RED     = 8'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_LENGTH_LIMIT = 8'd7;

  localparam logic [DIFF_W-1:0] THRESHOLD_RESET = 10'd100;
  localparam logic [TEXT_W-1:0] LIMIT_RESET     = 9'd30;

  localparam logic [KEY_W-1:0]   TWO_DIGIT_KEY   = 7'd10;
  localparam logic [2:0]         SHORT_TEXT_LEN  = 3'd3;
  localparam logic [2:0]         LONG_TEXT_LEN   = 3'd4;
  localparam logic [COUNT_W-1:0] COUNT_MAX       = 7'd127;
  localparam logic [TEXT_W-1:0]  TEXT_MAX        = 9'd511;

  localparam logic KIND_EVENT   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Bit i is set when key number i modulo 12 falls on a white key.
  localparam logic [11:0]  WHITE_PATTERN  = 12'b0101_1010_1101;
  localparam logic [127:0] WHITE_KEY_MASK = 128'({11{WHITE_PATTERN}});

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;
  localparam int unsigned FIFO_CNT_W = 3;

  typedef struct packed {
    logic               item_kind;
    logic [KEY_W-1:0]   event_key;
    logic               pressed;
    logic [FRAME_W-1:0] frame_number;
    logic [COUNT_W-1:0] frame_event_count;
    logic [TEXT_W-1:0]  frame_text_length;
    logic               frame_accepted;
    logic               last_of_run;
  } result_t;

endpackage

// ----- sv/key_color_change_event_detector.sv -----
// Top level of the key color change event detector.
// Input register, per-key press tracking, frame totals and a small result queue.
// Depends on kcced_pkg.

// Takes one sampled pixel per piano key and reports key press and release
// events plus one summary per frame. An item is accepted every cycle while
// the input register is empty or the result queue has room for two results;
// it is evaluated from the input register and its results are written into the result queue, which drives the
// output. The output port moves one result per cycle while m_axis_tready is high, so an item that causes both
// an event and a summary occupies the output for two results, and the sustained rate is
// one item per cycle as long as items cause at most one result on average and the output is not stalled.
// Configuration writes are always accepted and must only be made while idle.
module key_color_change_event_detector #(
  parameter int unsigned NUM_KEYS = 88
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [kcced_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [kcced_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // key_index[6:0], pixel_blue[14:7], pixel_green[22:15], pixel_red[30:23], zero.
  input  logic [kcced_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  input  logic                                  s_axis_tlast,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // event_key[6:0], pressed[7], frame_number[31:8], frame_event_count[38:32],
  // frame_text_length[47:39], frame_accepted[48], zero fill above.
  output logic [kcced_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // item_kind[0].
  output logic                                  m_axis_tuser,
  output logic                                  m_axis_tlast
);
  import kcced_pkg::*;

  localparam int unsigned KEY_IDX_W = $clog2(NUM_KEYS);
  localparam logic [KEY_W:0] KEY_LIMIT = (KEY_W + 1)'(NUM_KEYS);
  localparam logic [FIFO_CNT_W-1:0] FIFO_ROOM = FIFO_CNT_W'(FIFO_DEPTH - 2);
  localparam logic [FIFO_CNT_W-1:0] FIFO_FULL = FIFO_CNT_W'(FIFO_DEPTH);

  logic [DIFF_W-1:0] threshold_q;
  logic [CHAN_W-1:0] white_b_q, white_g_q, white_r_q;
  logic [CHAN_W-1:0] black_b_q, black_g_q, black_r_q;
  logic [TEXT_W-1:0] limit_q;

  logic              in_valid_q;
  logic [KEY_W-1:0]  key_q;
  logic [CHAN_W-1:0] pix_b_q, pix_g_q, pix_r_q;
  logic              fend_q;

  logic [NUM_KEYS-1:0] key_pressed_q, key_pressed_d;
  logic [FRAME_W-1:0]  frame_counter_q, frame_counter_d;
  logic [TEXT_W-1:0]   text_len_q, text_len_d;
  logic [COUNT_W-1:0]  event_cnt_q, event_cnt_d;

  result_t                fifo_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0]  count_q, count_d;

  logic                 advance, accept_in, pop;
  logic                 in_range, white, now_pressed, toggle;
  logic [KEY_IDX_W-1:0] key_sel;
  logic [CHAN_W-1:0]    ref_b, ref_g, ref_r, ad_b, ad_g, ad_r;
  logic [DIFF_W-1:0]    diff;
  logic [2:0]           len_add;
  logic [TEXT_W:0]      len_sum;
  logic [TEXT_W-1:0]    len_new;
  logic [COUNT_W-1:0]   cnt_new;
  logic                 frame_ok;
  result_t              ev_res, sm_res, head;
  logic [FIFO_CNT_W-1:0] n_push;

  assign cfg_ready_o   = 1'b1;
  assign advance       = in_valid_q && (count_q <= FIFO_ROOM);
  assign s_axis_tready = !in_valid_q || advance;
  assign accept_in     = s_axis_tvalid && s_axis_tready;
  assign pop           = m_axis_tvalid && m_axis_tready;

  assign in_range = {1'b0, key_q} < KEY_LIMIT;
  assign key_sel  = key_q[KEY_IDX_W-1:0];
  assign white    = WHITE_KEY_MASK[key_q];

  always_comb begin
    ref_b = white ? white_b_q : black_b_q;
    ref_g = white ? white_g_q : black_g_q;
    ref_r = white ? white_r_q : black_r_q;
    ad_b  = (pix_b_q > ref_b) ? pix_b_q - ref_b : ref_b - pix_b_q;
    ad_g  = (pix_g_q > ref_g) ? pix_g_q - ref_g : ref_g - pix_g_q;
    ad_r  = (pix_r_q > ref_r) ? pix_r_q - ref_r : ref_r - pix_r_q;
    diff  = {2'b00, ad_b} + {2'b00, ad_g} + {2'b00, ad_r};
  end

  assign now_pressed = diff > threshold_q;
  assign toggle      = in_range && (now_pressed != key_pressed_q[key_sel]);

  always_comb begin
    len_add = (key_q < TWO_DIGIT_KEY) ? SHORT_TEXT_LEN : LONG_TEXT_LEN;
    len_sum = {1'b0, text_len_q} + {{(TEXT_W - 2){1'b0}}, len_add};
    len_new = text_len_q;
    cnt_new = event_cnt_q;
    if (toggle) begin
      len_new = len_sum[TEXT_W] ? TEXT_MAX : len_sum[TEXT_W-1:0];
      if (event_cnt_q != COUNT_MAX) begin
        cnt_new = event_cnt_q + 1'b1;
      end
    end
    frame_ok = (len_new != '0) && (len_new < limit_q);
  end

  always_comb begin
    ev_res                   = '0;
    ev_res.item_kind         = KIND_EVENT;
    ev_res.event_key         = key_q;
    ev_res.pressed           = now_pressed;
    ev_res.frame_number      = frame_counter_q;
    ev_res.last_of_run       = !fend_q;
    sm_res                   = '0;
    sm_res.item_kind         = KIND_SUMMARY;
    sm_res.frame_number      = frame_counter_q;
    sm_res.frame_event_count = cnt_new;
    sm_res.frame_text_length = len_new;
    sm_res.frame_accepted    = frame_ok;
    sm_res.last_of_run       = 1'b1;
  end

  always_comb begin
    key_pressed_d   = key_pressed_q;
    frame_counter_d = frame_counter_q;
    text_len_d      = text_len_q;
    event_cnt_d     = event_cnt_q;
    n_push          = '0;
    if (advance) begin
      n_push = FIFO_CNT_W'(toggle) + FIFO_CNT_W'(fend_q);
      if (toggle) begin
        key_pressed_d[key_sel] = now_pressed;
      end
      if (fend_q) begin
        frame_counter_d = frame_counter_q + 1'b1;
        text_len_d      = '0;
        event_cnt_d     = '0;
      end else begin
        text_len_d  = len_new;
        event_cnt_d = cnt_new;
      end
    end
    wr_ptr_d = wr_ptr_q + n_push[FIFO_PTR_W-1:0];
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + n_push - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q     <= THRESHOLD_RESET;
      white_b_q       <= '0;
      white_g_q       <= '0;
      white_r_q       <= '0;
      black_b_q       <= '0;
      black_g_q       <= '0;
      black_r_q       <= '0;
      limit_q         <= LIMIT_RESET;
      in_valid_q      <= 1'b0;
      key_pressed_q   <= '0;
      frame_counter_q <= FRAME_W'(1);
      text_len_q      <= '0;
      event_cnt_q     <= '0;
      wr_ptr_q        <= '0;
      rd_ptr_q        <= '0;
      count_q         <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_CHANGE_THRESHOLD:  threshold_q <= cfg_data_i;
          CFG_WHITE_REF_BLUE:    white_b_q   <= cfg_data_i[CHAN_W-1:0];
          CFG_WHITE_REF_GREEN:   white_g_q   <= cfg_data_i[CHAN_W-1:0];
          CFG_WHITE_REF_RED:     white_r_q   <= cfg_data_i[CHAN_W-1:0];
          CFG_BLACK_REF_BLUE:    black_b_q   <= cfg_data_i[CHAN_W-1:0];
          CFG_BLACK_REF_GREEN:   black_g_q   <= cfg_data_i[CHAN_W-1:0];
          CFG_BLACK_REF_RED:     black_r_q   <= cfg_data_i[CHAN_W-1:0];
          CFG_TEXT_LENGTH_LIMIT: limit_q     <= cfg_data_i[TEXT_W-1:0];
          default: ;
        endcase
      end
      if (accept_in) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      key_pressed_q   <= key_pressed_d;
      frame_counter_q <= frame_counter_d;
      text_len_q      <= text_len_d;
      event_cnt_q     <= event_cnt_d;
      wr_ptr_q        <= wr_ptr_d;
      rd_ptr_q        <= rd_ptr_d;
      count_q         <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      key_q   <= s_axis_tdata[6:0];
      pix_b_q <= s_axis_tdata[14:7];
      pix_g_q <= s_axis_tdata[22:15];
      pix_r_q <= s_axis_tdata[30:23];
      fend_q  <= s_axis_tlast;
    end
    if (advance) begin
      if (toggle) begin
        fifo_q[wr_ptr_q] <= ev_res;
        if (fend_q) begin
          fifo_q[wr_ptr_q + 1'b1] <= sm_res;
        end
      end else if (fend_q) begin
        fifo_q[wr_ptr_q] <= sm_res;
      end
    end
  end

  assign head          = fifo_q[rd_ptr_q];
  assign m_axis_tvalid = count_q != '0;
  assign m_axis_tuser  = head.item_kind;
  assign m_axis_tlast  = head.last_of_run;
  assign m_axis_tdata  = OUT_DATA_W'({head.frame_accepted, head.frame_text_length,
                                      head.frame_event_count, head.frame_number,
                                      head.pressed, head.event_key});

`ifndef SYNTH
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FIFO_FULL)
    else $error("Result queue holds more items than its depth.");

  a_summary_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == KIND_SUMMARY)) |-> m_axis_tlast)
    else $error("A frame summary is not the last result of its item.");

  a_event_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == KIND_EVENT)) |->
      (m_axis_tdata[48:32] == '0))
    else $error("A key event carries nonzero summary fields.");

  a_frame_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && fend_q) |=>
      ((frame_counter_q == FRAME_W'($past(frame_counter_q) + 1'b1)) &&
       (text_len_q == '0) && (event_cnt_q == '0)))
    else $error("Frame totals did not restart after a frame end.");
`endif

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for key_color_change_event_detector.
// Drives key pixel samples and register writes, predicts every key event and
// frame summary in the testbench itself, and checks the output stream. Needs kcced_pkg.
module testbench;
  import kcced_pkg::*;

  localparam int unsigned NUM_KEYS       = 88;
  localparam int unsigned BLUE           = 0;
  localparam int unsigned GREEN          = 1;
  localparam int unsigned RED            = 2;
  localparam int unsigned MAX_CHARS      = 511;
  localparam int unsigned MAX_EVENTS     = 127;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned TIMEOUT_CYCLES = 500000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 8'd200;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
    logic              frame_end;
  } key_sample_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;

  key_color_change_event_detector #(
    .NUM_KEYS(NUM_KEYS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  key_sample_t sample_queue[$];
  reg_write_t  reg_write_queue[$];
  result_t     awaited_reports[$];
  int unsigned mismatch_count = 0;
  logic        idle_enabled = 1'b1;

  logic [DIFF_W-1:0]  press_threshold;
  logic [CHAN_W-1:0]  white_ref[3];
  logic [CHAN_W-1:0]  black_ref[3];
  logic [TEXT_W-1:0]  accept_limit;
  logic               key_is_down[NUM_KEYS];
  logic [FRAME_W-1:0] frame_no;
  int unsigned        frame_chars;
  int unsigned        frame_events;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic is_white_key(input logic [KEY_W-1:0] key);
    int unsigned pos;
    pos = (key + 9) % 12;
    case (pos)
      0, 2, 4, 5, 7, 9, 11: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic int unsigned abs_gap(input logic [CHAN_W-1:0] a, input logic [CHAN_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic int unsigned pick_pause();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!idle_enabled || roll < 65) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  task automatic reset_model();
    int unsigned k;
    press_threshold = THRESHOLD_RESET;
    accept_limit = LIMIT_RESET;
    for (k = 0; k < 3; k++) begin
      white_ref[k] = '0;
      black_ref[k] = '0;
    end
    for (k = 0; k < NUM_KEYS; k++) key_is_down[k] = 1'b0;
    frame_no = FRAME_W'(1);
    frame_chars = 0;
    frame_events = 0;
  endtask

  task automatic apply_reg_write(input reg_write_t wr);
    case (wr.index)
      CFG_CHANGE_THRESHOLD:  press_threshold = wr.data;
      CFG_WHITE_REF_BLUE:    white_ref[BLUE] = wr.data[7:0];
      CFG_WHITE_REF_GREEN:   white_ref[GREEN] = wr.data[7:0];
      CFG_WHITE_REF_RED:     white_ref[RED] = wr.data[7:0];
      CFG_BLACK_REF_BLUE:    black_ref[BLUE] = wr.data[7:0];
      CFG_BLACK_REF_GREEN:   black_ref[GREEN] = wr.data[7:0];
      CFG_BLACK_REF_RED:     black_ref[RED] = wr.data[7:0];
      CFG_TEXT_LENGTH_LIMIT: accept_limit = wr.data[8:0];
      default: ;
    endcase
  endtask

  task automatic predict_key_sample(input key_sample_t smp);
    result_t      reports[2];
    int unsigned  n_reports;
    int unsigned  diff;
    int unsigned  c;
    logic         now_down;
    logic [CHAN_W-1:0] pix[3];
    pix[BLUE] = smp.blue;
    pix[GREEN] = smp.green;
    pix[RED] = smp.red;
    n_reports = 0;
    if (smp.key < NUM_KEYS) begin
      diff = 0;
      for (c = 0; c < 3; c++) begin
        diff += abs_gap(pix[c], is_white_key(smp.key) ? white_ref[c] : black_ref[c]);
      end
      now_down = diff > press_threshold;
      if (now_down != key_is_down[smp.key]) begin
        key_is_down[smp.key] = now_down;
        frame_chars += (smp.key < 10) ? 3 : 4;
        if (frame_chars > MAX_CHARS) frame_chars = MAX_CHARS;
        if (frame_events < MAX_EVENTS) frame_events++;
        reports[0] = '0;
        reports[0].item_kind = KIND_EVENT;
        reports[0].event_key = smp.key;
        reports[0].pressed = now_down;
        reports[0].frame_number = frame_no;
        n_reports = 1;
      end
    end
    if (smp.frame_end) begin
      reports[n_reports] = '0;
      reports[n_reports].item_kind = KIND_SUMMARY;
      reports[n_reports].frame_number = frame_no;
      reports[n_reports].frame_event_count = COUNT_W'(frame_events);
      reports[n_reports].frame_text_length = TEXT_W'(frame_chars);
      reports[n_reports].frame_accepted = (frame_chars > 0) && (frame_chars < accept_limit);
      n_reports++;
      frame_no = frame_no + 1'b1;
      frame_chars = 0;
      frame_events = 0;
    end
    if (n_reports > 0) reports[n_reports-1].last_of_run = 1'b1;
    for (c = 0; c < n_reports; c++) awaited_reports.push_back(reports[c]);
  endtask

  task automatic check_field(input string name, input int unsigned exp_val,
                             input int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
      mismatch_count++;
    end
  endtask

  // Sample driver.
  int unsigned sample_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    key_sample_t smp;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      sample_gap <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        smp.key = s_axis_tdata[6:0];
        smp.blue = s_axis_tdata[14:7];
        smp.green = s_axis_tdata[22:15];
        smp.red = s_axis_tdata[30:23];
        smp.frame_end = s_axis_tlast;
        predict_key_sample(smp);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (sample_gap > 0) begin
          sample_gap <= sample_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (sample_queue.size() > 0) begin
          smp = sample_queue.pop_front();
          s_axis_tdata <= {1'b0, smp.red, smp.green, smp.blue, smp.key};
          s_axis_tlast <= smp.frame_end;
          s_axis_tvalid <= 1'b1;
          sample_gap <= pick_pause();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Register write driver.
  always @(posedge clk_i or negedge rst_ni) begin
    reg_write_t wr;
    if (!rst_ni) begin
      cfg_valid_i <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        wr.index = cfg_index_i;
        wr.data = cfg_data_i;
        apply_reg_write(wr);
      end
      if (!cfg_valid_i || cfg_ready_o) begin
        if (reg_write_queue.size() > 0) begin
          wr = reg_write_queue.pop_front();
          cfg_index_i <= wr.index;
          cfg_data_i <= wr.data;
          cfg_valid_i <= 1'b1;
        end else begin
          cfg_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  int unsigned report_stall = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    result_t exp_rep;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      report_stall <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_reports.size() == 0) begin
          $error("unexpected result: kind %0d, tdata %h", m_axis_tuser, m_axis_tdata);
          mismatch_count++;
        end else begin
          exp_rep = awaited_reports.pop_front();
          check_field("item_kind", exp_rep.item_kind, m_axis_tuser);
          check_field("event_key", exp_rep.event_key, m_axis_tdata[6:0]);
          check_field("pressed", exp_rep.pressed, m_axis_tdata[7]);
          check_field("frame_number", exp_rep.frame_number, m_axis_tdata[31:8]);
          check_field("frame_event_count", exp_rep.frame_event_count, m_axis_tdata[38:32]);
          check_field("frame_text_length", exp_rep.frame_text_length, m_axis_tdata[47:39]);
          check_field("frame_accepted", exp_rep.frame_accepted, m_axis_tdata[48]);
          check_field("last_of_run", exp_rep.last_of_run, m_axis_tlast);
        end
      end
      if (report_stall > 0) begin
        report_stall <= report_stall - 1;
        m_axis_tready <= 1'b0;
      end else if (idle_enabled && $urandom_range(0, 5) == 0) begin
        report_stall <= pick_pause();
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic queue_sample(input int unsigned key, input int unsigned blue,
                              input int unsigned green, input int unsigned red,
                              input logic frame_end);
    key_sample_t smp;
    smp.key = KEY_W'(key);
    smp.blue = CHAN_W'(blue);
    smp.green = CHAN_W'(green);
    smp.red = CHAN_W'(red);
    smp.frame_end = frame_end;
    sample_queue.push_back(smp);
  endtask

  task automatic queue_write(input logic [CFG_IDX_W-1:0] index, input int unsigned data);
    reg_write_t wr;
    wr.index = index;
    wr.data = CFG_DATA_W'(data);
    reg_write_queue.push_back(wr);
  endtask

  // Upper data bits beyond a register's width are filled randomly; they must be dropped.
  task automatic queue_setting(input int unsigned threshold, input int unsigned wb,
                               input int unsigned wg, input int unsigned wr,
                               input int unsigned bb, input int unsigned bg,
                               input int unsigned br, input int unsigned limit);
    queue_write(CFG_CHANGE_THRESHOLD, threshold);
    queue_write(CFG_WHITE_REF_BLUE, ($urandom_range(0, 3) << 8) | wb);
    queue_write(CFG_WHITE_REF_GREEN, ($urandom_range(0, 3) << 8) | wg);
    queue_write(CFG_WHITE_REF_RED, ($urandom_range(0, 3) << 8) | wr);
    queue_write(CFG_BLACK_REF_BLUE, ($urandom_range(0, 3) << 8) | bb);
    queue_write(CFG_BLACK_REF_GREEN, ($urandom_range(0, 3) << 8) | bg);
    queue_write(CFG_BLACK_REF_RED, ($urandom_range(0, 3) << 8) | br);
    queue_write(CFG_TEXT_LENGTH_LIMIT, ($urandom_range(0, 1) << 9) | limit);
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (sample_queue.size() != 0 || s_axis_tvalid || reg_write_queue.size() != 0 ||
           cfg_valid_i || awaited_reports.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic queue_random_sample(input int unsigned key, input logic frame_end);
    int unsigned mode;
    int unsigned c;
    int          val;
    int unsigned pix[3];
    mode = $urandom_range(0, 3);
    for (c = 0; c < 3; c++) begin
      val = (key < NUM_KEYS && !is_white_key(key)) ? black_ref[c] : white_ref[c];
      if (mode == 1) val += $urandom_range(0, 80) - 40;
      else if (mode >= 2) val = $urandom_range(0, 255);
      if (val < 0) val = 0;
      if (val > 255) val = 255;
      pix[c] = val;
    end
    queue_sample(key, pix[BLUE], pix[GREEN], pix[RED], frame_end);
  endtask

  task automatic queue_random_frame(input int unsigned n);
    int unsigned start_key;
    int unsigned i;
    int unsigned key;
    start_key = $urandom_range(0, NUM_KEYS - 1);
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) key = $urandom_range(0, 127);
      else key = (start_key + i) % NUM_KEYS;
      queue_random_sample(key, (i == n - 1) || ($urandom_range(0, 39) == 0));
    end
  endtask

  task automatic queue_random_phase(input int unsigned n_samples);
    int unsigned queued;
    int unsigned n;
    queued = 0;
    while (queued < n_samples) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      queue_random_frame(n);
      queued += n;
    end
  endtask

  initial begin
    int unsigned p;
    int unsigned i;
    reset_model();
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: threshold 100, all references black, limit 30.
    queue_sample(0, 0, 0, 0, 1'b0);
    queue_sample(0, 255, 255, 255, 1'b0);
    queue_sample(87, 255, 0, 0, 1'b0);
    queue_sample(9, 0, 200, 0, 1'b0);
    queue_sample(10, 0, 0, 101, 1'b0);
    queue_sample(11, 100, 0, 0, 1'b0);
    queue_sample(88, 255, 255, 255, 1'b0);
    queue_sample(127, 255, 255, 255, 1'b1);
    queue_sample(0, 0, 0, 0, 1'b1);
    queue_sample(5, 0, 0, 0, 1'b1);
    for (i = 20; i < 28; i++) queue_sample(i, 255, 255, 255, i == 27);
    wait_idle();

    queue_write(CFG_TEXT_LENGTH_LIMIT, 7);
    wait_idle();
    queue_sample(1, 255, 255, 255, 1'b0);
    queue_sample(12, 255, 255, 255, 1'b1);
    queue_sample(1, 0, 0, 0, 1'b0);
    queue_sample(2, 255, 255, 255, 1'b1);
    wait_idle();

    for (p = 0; p < 9; p++) begin
      idle_enabled = $urandom_range(0, 3) != 0;
      case (p)
        0: queue_setting(1023, $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 255), 0);
        1: queue_setting(0, 0, 0, 0, 0, 0, 0, 511);
        2: queue_setting(765, 255, 255, 255, 255, 255, 255, 1);
        default: begin
          queue_setting(($urandom_range(0, 4) == 0) ? $urandom_range(766, 1023)
                                                    : $urandom_range(0, 300),
                        $urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 120));
          if (p == 4) queue_write(CFG_UNUSED_INDEX, $urandom_range(0, 1023));
        end
      endcase
      wait_idle();
      // One frame long enough to saturate both the event count and the text length.
      if (p == 1) begin
        for (i = 0; i < 140; i++) begin
          queue_sample(50, (i % 2 == 0) ? 255 : 0, 0, 0, i == 139);
        end
      end
      queue_random_phase(68);
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk_i);
    $display("FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/kcced_pkg.sv
sv/key_color_change_event_detector.sv
tb/testbench.sv
